// File: sv/csc_pkg.sv
package csc_pkg;

   // default number of contact slots
   localparam int SLOTS_DEF = 5;

   // reset value of the match radius register (0.1 with 20 fraction bits)
   localparam logic [35:0] RADIUS_RESET = 36'd104858;

   localparam int RADIUS_W = 36;
   localparam int DIST_W   = 34;

   // request kinds
   localparam logic REQ_ADD   = 1'b0;
   localparam logic REQ_CLEAR = 1'b1;

   // result actions
   localparam logic [2:0] ACT_MERGE   = 3'd0;
   localparam logic [2:0] ACT_FREE    = 3'd1;
   localparam logic [2:0] ACT_REPLACE = 3'd2;
   localparam logic [2:0] ACT_DISCARD = 3'd3;
   localparam logic [2:0] ACT_CLEAR   = 3'd4;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } point_type;

   typedef struct packed {
      logic signed [23:0] normal;
      logic signed [23:0] bias;
      logic signed [23:0] tangent;
   } impulse_type;

   typedef struct packed {
      point_type          a;
      point_type          b;
      logic signed [15:0] depth;
      impulse_type        imp;
   } slot_entry_type;

   // write controls from the sequencer to the slot store
   typedef struct packed {
      logic wr_en;
      logic clear_all;
   } store_ctl_type;

endpackage

// File: sv/csc_req_if.sv
interface csc_req_if;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic signed [15:0] point_a_x;
   logic signed [15:0] point_a_y;
   logic signed [15:0] point_a_z;
   logic signed [15:0] point_b_x;
   logic signed [15:0] point_b_y;
   logic signed [15:0] point_b_z;
   logic signed [15:0] depth;
   logic signed [23:0] normal_impulse;
   logic signed [23:0] bias_impulse;
   logic signed [23:0] tangent_impulse;

   modport source (
      output valid, req_type, point_a_x, point_a_y, point_a_z,
             point_b_x, point_b_y, point_b_z, depth,
             normal_impulse, bias_impulse, tangent_impulse,
      input  ready
   );
   modport sink (
      input  valid, req_type, point_a_x, point_a_y, point_a_z,
             point_b_x, point_b_y, point_b_z, depth,
             normal_impulse, bias_impulse, tangent_impulse,
      output ready
   );
endinterface

// File: sv/csc_rsp_if.sv
interface csc_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         action;
   logic [2:0]         slot;
   logic signed [23:0] kept_normal;
   logic signed [23:0] kept_bias;
   logic signed [23:0] kept_tangent;

   modport source (
      output valid, action, slot, kept_normal, kept_bias, kept_tangent,
      input  ready
   );
   modport sink (
      input  valid, action, slot, kept_normal, kept_bias, kept_tangent,
      output ready
   );
endinterface

// File: sv/csc_csr_if.sv
interface csc_csr_if;
   logic        valid;
   logic        ready;
   logic [35:0] match_radius_sq;

   modport source (
      output valid, match_radius_sq,
      input  ready
   );
   modport sink (
      input  valid, match_radius_sq,
      output ready
   );
endinterface

// File: sv/contact_slot_cache_top.sv
// Contact slot cache: keeps up to SLOTS contact points for one body pair.
// An add request is compared slot by slot against the stored contacts with
// one shared squared-distance unit; a valid slot goes through A distance, B
// distance and compare, an empty slot only through the scan step. A match ends
// the scan at that slot. A clear is answered straight from idle. One request
// is worked on at a time, and the next is taken once the result has left the
// output register. The match radius may only be written while idle.
module contact_slot_cache_top
   import csc_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
)(
   input  logic       clock,
   input  logic       reset,
   csc_req_if.sink    req_ch,
   csc_rsp_if.source  rsp_ch,
   csc_csr_if.sink    csr_ch
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DIST_B = 3'd2;
   localparam logic [2:0] S_CMP    = 3'd3;
   localparam logic [2:0] S_DECIDE = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [RADIUS_W-1:0] radius_ff, radius_in;
   slot_entry_type      cur_ff, cur_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                have_min_ff, have_min_in;
   logic signed [15:0]  min_dep_ff, min_dep_in;
   logic [IDX_W-1:0]    min_idx_ff, min_idx_in;
   logic                a_hit_ff, a_hit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          action_ff, action_in;
   logic [2:0]          slot_ff, slot_in;
   impulse_type         kept_ff, kept_in;

   store_ctl_type       ctl;
   logic [IDX_W-1:0]    wr_idx;
   slot_entry_type      wr_data;
   slot_entry_type      rd_data;
   logic [SLOTS-1:0]    valid;

   logic                sel_b;
   point_type           dist_p, dist_q;
   logic [DIST_W-1:0]   dist_sq;
   logic                dist_hit;
   logic                req_fire;
   logic                free_any;
   logic [IDX_W-1:0]    free_idx;
   logic [IDX_W+2:0]    slot_ext;
   logic [IDX_W-1:0]    out_idx;

   csc_slot_store #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rd_idx  (idx_ff),
      .rd_data (rd_data),
      .valid   (valid)
   );

   // shared distance unit: A points, then B points of the current slot
   assign dist_p = sel_b ? rd_data.b : rd_data.a;
   assign dist_q = sel_b ? cur_ff.b  : cur_ff.a;

   csc_dist_unit u_dist (
      .clock   (clock),
      .p       (dist_p),
      .q       (dist_q),
      .dist_sq (dist_sq)
   );

   assign dist_hit = {{(RADIUS_W - DIST_W){1'b0}}, dist_sq} < radius_ff;

   // handshakes
   assign req_ch.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // lowest free slot
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid[i]) begin
            free_any = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      have_min_in  = have_min_ff;
      min_dep_in   = min_dep_ff;
      min_idx_in   = min_idx_ff;
      a_hit_in     = a_hit_ff;
      rsp_valid_in = rsp_valid_ff;
      action_in    = action_ff;
      out_idx      = '0;
      kept_in      = kept_ff;
      sel_b        = 1'b0;
      ctl          = '0;
      wr_idx       = idx_ff;
      wr_data      = cur_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cur_in.a     = {req_ch.point_a_x, req_ch.point_a_y, req_ch.point_a_z};
               cur_in.b     = {req_ch.point_b_x, req_ch.point_b_y, req_ch.point_b_z};
               cur_in.depth = req_ch.depth;
               cur_in.imp   = {req_ch.normal_impulse, req_ch.bias_impulse,
                               req_ch.tangent_impulse};
               if (req_ch.req_type == REQ_CLEAR) begin
                  ctl.clear_all = 1'b1;
                  rsp_valid_in  = 1'b1;
                  action_in     = ACT_CLEAR;
                  kept_in       = '0;
               end else begin
                  idx_in      = '0;
                  have_min_in = 1'b0;
                  state_in    = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (valid[idx_ff]) begin
               // track the shallowest slot, last one wins ties
               if (!have_min_ff || ($signed(rd_data.depth) <= $signed(min_dep_ff))) begin
                  have_min_in = 1'b1;
                  min_dep_in  = rd_data.depth;
                  min_idx_in  = idx_ff;
               end
               state_in = S_DIST_B;
            end else if (idx_ff == LAST_IDX) begin
               state_in = S_DECIDE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         S_DIST_B: begin
            sel_b    = 1'b1;
            a_hit_in = dist_hit;
            state_in = S_CMP;
         end

         S_CMP: begin
            if (a_hit_ff && dist_hit) begin
               // merge: new position, old impulses
               ctl.wr_en     = 1'b1;
               wr_data.imp   = rd_data.imp;
               rsp_valid_in  = 1'b1;
               action_in     = ACT_MERGE;
               out_idx       = idx_ff;
               kept_in       = rd_data.imp;
               state_in      = S_IDLE;
            end else if (idx_ff == LAST_IDX) begin
               state_in = S_DECIDE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SCAN;
            end
         end

         S_DECIDE: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (free_any) begin
               ctl.wr_en = 1'b1;
               wr_idx    = free_idx;
               action_in = ACT_FREE;
               out_idx   = free_idx;
               kept_in   = cur_ff.imp;
            end else if ($signed(cur_ff.depth) < $signed(min_dep_ff)) begin
               action_in = ACT_DISCARD;
               kept_in   = '0;
            end else begin
               ctl.wr_en = 1'b1;
               wr_idx    = min_idx_ff;
               action_in = ACT_REPLACE;
               out_idx   = min_idx_ff;
               kept_in   = cur_ff.imp;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // slot field is the index masked to three bits
      slot_ext = {3'b000, out_idx};
      slot_in  = slot_ff;
      if (!rsp_valid_ff && rsp_valid_in) begin
         slot_in = slot_ext[2:0];
      end
   end

   // match radius register
   always_comb begin
      radius_in = radius_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         radius_in = csr_ch.match_radius_sq;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         radius_ff    <= RADIUS_RESET;
         rsp_valid_ff <= 1'b0;
         have_min_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radius_ff    <= radius_in;
         rsp_valid_ff <= rsp_valid_in;
         have_min_ff  <= have_min_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      idx_ff     <= idx_in;
      min_dep_ff <= min_dep_in;
      min_idx_ff <= min_idx_in;
      a_hit_ff   <= a_hit_in;
      action_ff  <= action_in;
      slot_ff    <= slot_in;
      kept_ff    <= kept_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.action       = action_ff;
   assign rsp_ch.slot         = slot_ff;
   assign rsp_ch.kept_normal  = kept_ff.normal;
   assign rsp_ch.kept_bias    = kept_ff.bias;
   assign rsp_ch.kept_tangent = kept_ff.tangent;

endmodule

// File: sv/csc_dist_unit.sv
module csc_dist_unit
   import csc_pkg::*;
(
   input  logic              clock,
   input  point_type         p,
   input  point_type         q,
   output logic [DIST_W-1:0] dist_sq
);

   logic signed [16:0]       d_x, d_y, d_z;
   logic signed [DIST_W-1:0] sq_x, sq_y, sq_z;
   logic [DIST_W-1:0]        dist_sq_ff, dist_sq_in;

   // exact 17-bit differences, squared; each square is below 2^32
   always_comb begin
      d_x  = {p.x[15], p.x} - {q.x[15], q.x};
      d_y  = {p.y[15], p.y} - {q.y[15], q.y};
      d_z  = {p.z[15], p.z} - {q.z[15], q.z};
      sq_x = d_x * d_x;
      sq_y = d_y * d_y;
      sq_z = d_z * d_z;
      dist_sq_in = DIST_W'(unsigned'(sq_x)) + DIST_W'(unsigned'(sq_y))
                 + DIST_W'(unsigned'(sq_z));
   end

   always_ff @(posedge clock) begin
      dist_sq_ff <= dist_sq_in;
   end

   assign dist_sq = dist_sq_ff;

endmodule

// File: sv/csc_slot_store.sv
module csc_slot_store
   import csc_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF,
   parameter int IDX_W = 3
)(
   input  logic             clock,
   input  logic             reset,
   input  store_ctl_type    ctl,
   input  logic [IDX_W-1:0] wr_idx,
   input  slot_entry_type   wr_data,
   input  logic [IDX_W-1:0] rd_idx,
   output slot_entry_type   rd_data,
   output logic [SLOTS-1:0] valid
);

   slot_entry_type   entry_ff [SLOTS];
   logic [SLOTS-1:0] valid_ff, valid_in;

   // valid bits: cleared at once, set by a write
   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear_all) begin
         valid_in = '0;
      end else if (ctl.wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // slot contents, no reset
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         entry_ff[wr_idx] <= wr_data;
      end
   end

   assign rd_data = entry_ff[rd_idx];
   assign valid   = valid_ff;

endmodule

// File: tb/sv/tb_contact_slot_cache_top.sv
module tb_contact_slot_cache_top;
   import csc_pkg::*;

   localparam int NSLOTS          = SLOTS_DEF;
   localparam int NANCHORS        = 8;
   localparam int PHASES          = 7;
   localparam int ITEMS_PER_PHASE = 195;
   localparam int LONG_HOLD       = 300;
   localparam int CYCLE_LIMIT     = 400000;

   // one request as offered on the input channel
   typedef struct {
      logic               kind;
      point_type          pa;
      point_type          pb;
      logic signed [15:0] depth;
      impulse_type        imp;
   } contact_req_type;

   // one result as seen on the output channel
   typedef struct {
      logic [2:0]  action;
      logic [2:0]  slot;
      impulse_type kept;
   } slot_result_type;

   // Shadow copy of the slot store: predicts each result at acceptance and
   // checks results in order against those predictions.
   class slot_cache_checker;
      logic [35:0]        radius;
      logic               occupied[NSLOTS];
      point_type          at_a[NSLOTS];
      point_type          at_b[NSLOTS];
      logic signed [15:0] at_depth[NSLOTS];
      impulse_type        at_imp[NSLOTS];
      slot_result_type    awaited_results[$];
      int                 errors;
      int                 checked;
      int                 action_count[5];

      function new();
         radius = RADIUS_RESET;
         foreach (occupied[i]) occupied[i] = 1'b0;
         foreach (action_count[i]) action_count[i] = 0;
         errors  = 0;
         checked = 0;
      endfunction

      function void set_radius(logic [35:0] value);
         radius = value;
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction

      // exact squared distance, 20 fraction bits
      function longint unsigned span_sq(point_type p, point_type q);
         longint dx, dy, dz;
         dx = longint'(p.x) - longint'(q.x);
         dy = longint'(p.y) - longint'(q.y);
         dz = longint'(p.z) - longint'(q.z);
         return dx * dx + dy * dy + dz * dz;
      endfunction

      function void fill(int idx, contact_req_type r, impulse_type imp);
         occupied[idx] = 1'b1;
         at_a[idx]     = r.pa;
         at_b[idx]     = r.pb;
         at_depth[idx] = r.depth;
         at_imp[idx]   = imp;
      endfunction

      function slot_result_type predict_outcome(contact_req_type r);
         slot_result_type    res;
         logic signed [15:0] low_depth;
         int                 low_slot;
         bit                 have_low;
         res.action = ACT_CLEAR;
         res.slot   = '0;
         res.kept   = '0;
         if (r.kind == REQ_CLEAR) begin
            foreach (occupied[i]) occupied[i] = 1'b0;
            return res;
         end
         have_low  = 1'b0;
         low_depth = '0;
         low_slot  = 0;
         // scan for a match, tracking the shallowest slot (last one on ties)
         for (int i = 0; i < NSLOTS; i++) begin
            if (!occupied[i]) continue;
            if (span_sq(at_a[i], r.pa) < radius && span_sq(at_b[i], r.pb) < radius) begin
               res.action = ACT_MERGE;
               res.slot   = 3'(i);
               res.kept   = at_imp[i];
               fill(i, r, at_imp[i]);
               return res;
            end
            if (!have_low || at_depth[i] <= low_depth) begin
               have_low  = 1'b1;
               low_depth = at_depth[i];
               low_slot  = i;
            end
         end
         for (int i = 0; i < NSLOTS; i++) begin
            if (!occupied[i]) begin
               res.action = ACT_FREE;
               res.slot   = 3'(i);
               res.kept   = r.imp;
               fill(i, r, r.imp);
               return res;
            end
         end
         // store full: shallower newcomer is dropped
         if (r.depth < low_depth) begin
            res.action = ACT_DISCARD;
            return res;
         end
         res.action = ACT_REPLACE;
         res.slot   = 3'(low_slot);
         res.kept   = r.imp;
         fill(low_slot, r, r.imp);
         return res;
      endfunction

      function void note_request(contact_req_type r);
         awaited_results.push_back(predict_outcome(r));
      endfunction

      task report(string what);
         errors++;
         if (errors <= 40) $display("%0t ERROR %s", $time, what);
      endtask

      task check_result(slot_result_type got);
         slot_result_type want;
         if (awaited_results.size() == 0) begin
            report($sformatf("result with no request pending: action %0d slot %0d",
                             got.action, got.slot));
            return;
         end
         want = awaited_results.pop_front();
         checked++;
         if (want.action <= ACT_CLEAR) action_count[want.action]++;
         if (got.action !== want.action)
            report($sformatf("action %0d, want %0d", got.action, want.action));
         if (got.slot !== want.slot)
            report($sformatf("slot %0d, want %0d", got.slot, want.slot));
         if (got.kept.normal !== want.kept.normal)
            report($sformatf("kept_normal %0d, want %0d", got.kept.normal, want.kept.normal));
         if (got.kept.bias !== want.kept.bias)
            report($sformatf("kept_bias %0d, want %0d", got.kept.bias, want.kept.bias));
         if (got.kept.tangent !== want.kept.tangent)
            report($sformatf("kept_tangent %0d, want %0d",
                             got.kept.tangent, want.kept.tangent));
      endtask
   endclass

   logic clock;
   logic reset;
   bit   hold_rsp_long;
   int   cycles;

   point_type anchor_a[NANCHORS];
   point_type anchor_b[NANCHORS];

   slot_cache_checker cache_check = new();

   csc_req_if req_if();
   csc_rsp_if rsp_if();
   csc_csr_if csr_if();

   contact_slot_cache_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // stimulus helpers
   function automatic point_type rand_point();
      point_type p;
      p.x = 16'($urandom());
      p.y = 16'($urandom());
      p.z = 16'($urandom());
      return p;
   endfunction

   function automatic point_type pick_anchor();
      point_type p;
      p = rand_point();
      // now and then sit on the corners of the coordinate range
      if ($urandom_range(7) == 0) begin
         p.x = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         p.y = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         p.z = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      end
      return p;
   endfunction

   function automatic logic signed [15:0] nudge(logic signed [15:0] base, int spread);
      int v;
      v = int'(base) + int'($urandom_range(2 * spread)) - spread;
      return v[15:0];
   endfunction

   function automatic point_type near(point_type p, int spread);
      point_type q;
      q.x = nudge(p.x, spread);
      q.y = nudge(p.y, spread);
      q.z = nudge(p.z, spread);
      return q;
   endfunction

   function automatic impulse_type rand_impulse();
      impulse_type imp;
      imp.normal  = 24'($urandom());
      imp.bias    = 24'($urandom());
      imp.tangent = 24'($urandom());
      return imp;
   endfunction

   function automatic contact_req_type add_request(int ax, int ay, int az, int bx, int by,
                                                   int bz, int dep, int n, int b, int t);
      contact_req_type r;
      r.kind        = REQ_ADD;
      r.pa.x        = 16'(ax);
      r.pa.y        = 16'(ay);
      r.pa.z        = 16'(az);
      r.pb.x        = 16'(bx);
      r.pb.y        = 16'(by);
      r.pb.z        = 16'(bz);
      r.depth       = 16'(dep);
      r.imp.normal  = 24'(n);
      r.imp.bias    = 24'(b);
      r.imp.tangent = 24'(t);
      return r;
   endfunction

   function automatic contact_req_type clear_request();
      contact_req_type r;
      r.kind  = REQ_CLEAR;
      r.pa    = rand_point();
      r.pb    = rand_point();
      r.depth = 16'($urandom());
      r.imp   = rand_impulse();
      return r;
   endfunction

   // mostly contacts around a few anchors, some partial matches, some noise
   function automatic contact_req_type random_request(int spread);
      contact_req_type r;
      int              roll;
      int              k;
      roll    = $urandom_range(99);
      k       = $urandom_range(NANCHORS - 1);
      r.kind  = (roll < 4) ? REQ_CLEAR : REQ_ADD;
      r.pa    = rand_point();
      r.pb    = rand_point();
      if (roll >= 22) begin
         r.pa = near(anchor_a[k], spread);
         r.pb = (roll < 30) ? rand_point() : near(anchor_b[k], spread);
      end
      // small depths make ties common
      if ($urandom_range(1)) r.depth = 16'(int'($urandom_range(4)) - 2);
      else r.depth = 16'($urandom());
      r.imp = rand_impulse();
      return r;
   endfunction

   // sender: bursts of random length separated by random gaps
   task automatic send_batch(input contact_req_type items[$]);
      int burst;
      int gap;
      burst = 0;
      foreach (items[i]) begin
         if (burst == 0) begin
            burst = $urandom_range(16, 1);
            gap   = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 1);
            if (gap > 0) begin
               req_if.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         req_if.valid           <= 1'b1;
         req_if.req_type        <= items[i].kind;
         req_if.point_a_x       <= items[i].pa.x;
         req_if.point_a_y       <= items[i].pa.y;
         req_if.point_a_z       <= items[i].pa.z;
         req_if.point_b_x       <= items[i].pb.x;
         req_if.point_b_y       <= items[i].pb.y;
         req_if.point_b_z       <= items[i].pb.z;
         req_if.depth           <= items[i].depth;
         req_if.normal_impulse  <= items[i].imp.normal;
         req_if.bias_impulse    <= items[i].imp.bias;
         req_if.tangent_impulse <= items[i].imp.tangent;
         do @(posedge clock); while (req_if.ready !== 1'b1);
         burst--;
      end
      req_if.valid <= 1'b0;
   endtask

   task automatic write_radius(input logic [35:0] value);
      csr_if.valid           <= 1'b1;
      csr_if.match_radius_sq <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      csr_if.valid <= 1'b0;
   endtask

   // one edge first, so the request taken at the last edge is already noted
   task automatic wait_idle();
      @(posedge clock);
      while (cache_check.pending() != 0) @(posedge clock);
   endtask

   // receiver: changing stall modes, plus one long hold-off on request
   initial begin
      int mode;
      int mode_left;
      int stall;
      rsp_if.ready = 1'b0;
      mode_left    = 0;
      stall        = 0;
      mode         = 0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_rsp_long) begin
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_rsp_long = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(3);
               mode_left = $urandom_range(200, 20);
            end
            mode_left--;
            case (mode)
               0: begin
                  rsp_if.ready <= 1'b1;
               end
               1: begin
                  rsp_if.ready <= 1'($urandom_range(1));
               end
               2: begin
                  if (stall > 0) begin
                     stall--;
                     rsp_if.ready <= 1'b0;
                  end else if ($urandom_range(7) == 0) begin
                     stall = $urandom_range(12, 1);
                     rsp_if.ready <= 1'b0;
                  end else begin
                     rsp_if.ready <= 1'b1;
                  end
               end
               default: begin
                  rsp_if.ready <= ($urandom_range(9) != 0);
               end
            endcase
         end
      end
   end

   // watch all three channels; results are checked before new requests are noted
   always @(posedge clock) begin
      slot_result_type got;
      contact_req_type seen;
      if (reset === 1'b0) begin
         if (csr_if.valid === 1'b1 && csr_if.ready === 1'b1)
            cache_check.set_radius(csr_if.match_radius_sq);
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            got.action       = rsp_if.action;
            got.slot         = rsp_if.slot;
            got.kept.normal  = rsp_if.kept_normal;
            got.kept.bias    = rsp_if.kept_bias;
            got.kept.tangent = rsp_if.kept_tangent;
            cache_check.check_result(got);
         end
         if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
            seen.kind        = req_if.req_type;
            seen.pa.x        = req_if.point_a_x;
            seen.pa.y        = req_if.point_a_y;
            seen.pa.z        = req_if.point_a_z;
            seen.pb.x        = req_if.point_b_x;
            seen.pb.y        = req_if.point_b_y;
            seen.pb.z        = req_if.point_b_z;
            seen.depth       = req_if.depth;
            seen.imp.normal  = req_if.normal_impulse;
            seen.imp.bias    = req_if.bias_impulse;
            seen.imp.tangent = req_if.tangent_impulse;
            cache_check.note_request(seen);
         end
      end
   end

   // watchdog
   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               cache_check.pending());
      $display("contact_slot_cache_top: mismatch");
      $finish;
   end

   initial begin
      contact_req_type batch[$];
      logic [35:0]     radius_plan[PHASES];
      int              spread_plan[PHASES];
      logic [63:0]     wide;

      radius_plan = '{RADIUS_RESET, 36'hF_FFFF_FFFF, 36'd0, 36'd4194304, 36'd1, 36'd0,
                      RADIUS_RESET};
      spread_plan = '{150, 150, 20, 1200, 1, 300, 150};

      reset                  = 1'b1;
      hold_rsp_long          = 1'b0;
      req_if.valid           = 1'b0;
      req_if.req_type        = REQ_ADD;
      req_if.point_a_x       = '0;
      req_if.point_a_y       = '0;
      req_if.point_a_z       = '0;
      req_if.point_b_x       = '0;
      req_if.point_b_y       = '0;
      req_if.point_b_z       = '0;
      req_if.depth           = '0;
      req_if.normal_impulse  = '0;
      req_if.bias_impulse    = '0;
      req_if.tangent_impulse = '0;
      csr_if.valid           = 1'b0;
      csr_if.match_radius_sq = RADIUS_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset radius
      batch.push_back(clear_request());                              // clear when empty
      batch.push_back(add_request(32767, 32767, 32767, -32768, -32768, -32768,
                                  32767, 8388607, 8388607, 8388607));
      batch.push_back(add_request(32767, 32767, 32767, -32768, -32768, -32768,
                                  10, -8388608, -8388608, -8388608));  // merge keeps old
      batch.push_back(add_request(0, 0, 0, 0, 0, 0, -32768, -8388608, -8388608, -8388608));
      batch.push_back(add_request(1000, 1000, 1000, -1000, -1000, -1000, 5, 1, 2, 3));
      batch.push_back(add_request(-5000, -5000, -5000, 5000, 5000, 5000, 5, 4, 5, 6));
      batch.push_back(add_request(1400, 1000, 1000, -1000, -1000, -1000, 100, 7, 8, 9));
      // full: equal depth to the shallowest still replaces
      batch.push_back(add_request(20000, 0, 0, 0, 20000, 0, -32768, 11, 12, 13));
      batch.push_back(add_request(20000, 0, 0, 0, 20000, 0, 20, 14, 15, 16));
      // two slots tie on least depth, new one shallower: dropped
      batch.push_back(add_request(-20000, -20000, -20000, 20000, 20000, 20000, 4, 17, 18, 19));
      // within radius of two slots: lower slot wins
      batch.push_back(add_request(1200, 1000, 1000, -1000, -1000, -1000, 50, 20, 21, 22));
      // distance exactly at the radius is no match
      batch.push_back(add_request(1723, 1023, 1000, -1000, -1000, -1000, 4, 23, 24, 25));
      // one step inside the radius matches
      batch.push_back(add_request(1723, 1022, 1000, -1000, -1000, -1000, 7, 26, 27, 28));
      // A side matches, B side does not
      batch.push_back(add_request(32767, 32767, 32767, 0, 0, 0, 32767, 29, 30, 31));
      batch.push_back(add_request(0, 0, 0, 20000, 0, 0, 3, 32, 33, 34));
      batch.push_back(clear_request());                              // clear when full
      batch.push_back(add_request(-32768, -32768, -32768, 32767, 32767, 32767, 0, 0, 0, 0));
      batch.push_back(add_request(0, 0, 0, 0, 0, 0, 0, -1, -1, -1));
      batch.push_back(clear_request());
      send_batch(batch);

      // random phases, each under its own match radius
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         if (p == 5) begin
            wide           = {$urandom(), $urandom()};
            radius_plan[p] = wide[35:0] >> $urandom_range(35);
         end
         write_radius(radius_plan[p]);
         for (int k = 0; k < NANCHORS; k++) begin
            anchor_a[k] = pick_anchor();
            anchor_b[k] = pick_anchor();
         end
         batch.delete();
         repeat (ITEMS_PER_PHASE) batch.push_back(random_request(spread_plan[p]));
         // first phase: receiver backs off so the block fills and stalls input
         if (p == 0) hold_rsp_long = 1'b1;
         send_batch(batch);
      end

      wait_idle();
      repeat (40) @(posedge clock);

      $display("checked %0d results over %0d radius settings", cache_check.checked,
               PHASES + 1);
      $display("merged %0d, free slot %0d, replaced %0d, discarded %0d, cleared %0d",
               cache_check.action_count[ACT_MERGE], cache_check.action_count[ACT_FREE],
               cache_check.action_count[ACT_REPLACE], cache_check.action_count[ACT_DISCARD],
               cache_check.action_count[ACT_CLEAR]);
      if (cache_check.errors == 0 && cache_check.pending() == 0)
         $display("contact_slot_cache_top: match");
      else
         $display("contact_slot_cache_top: mismatch");
      $finish;
   end

endmodule
